// ===== rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    localparam int CH_BITS      = 8;
    localparam int QUO_BITS     = 16;
    localparam int SPAN_BITS    = CH_BITS + 3;
    localparam int SAT_NUM_BITS = CH_BITS + QUO_BITS;
    localparam int CHAN_MAX     = (1 << CH_BITS) - 1;
    localparam int GREY_RATIO   = 10000;

    // A pixel is grey when delta * GREY_RATIO does not exceed CHAN_MAX.
    localparam logic [CH_BITS-1:0] GREY_LIMIT = CH_BITS'(CHAN_MAX / GREY_RATIO);

    typedef struct packed {
        logic                  grey;
        logic [CH_BITS-1:0]    mx;
        logic [CH_BITS-1:0]    sat_rem;
        logic [QUO_BITS-1:0]   sat_low;
        logic [QUO_BITS-1:0]   sat_quo;
        logic [SPAN_BITS-1:0]  hue_rem;
        logic [QUO_BITS-1:0]   hue_quo;
        logic [SPAN_BITS-1:0]  span;
    } stage_t;

endpackage

// ===== rtl/rgbhsv_prep.sv =====
module rgbhsv_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic [rgbhsv_pkg::CH_BITS-1:0] red,
    input  logic [rgbhsv_pkg::CH_BITS-1:0] green,
    input  logic [rgbhsv_pkg::CH_BITS-1:0] blue,
    output logic                          valid_out,
    output rgbhsv_pkg::stage_t            data_out
);
    import rgbhsv_pkg::*;

    logic                    valid_reg;
    stage_t                  data_reg;
    stage_t                  data_next;
    logic [CH_BITS-1:0]      mx;
    logic [CH_BITS-1:0]      mn;
    logic [CH_BITS-1:0]      delta;
    logic [SPAN_BITS-1:0]    span;
    logic [SPAN_BITS-1:0]    h6;
    logic [SAT_NUM_BITS-1:0] sat_num;

    always_comb
    begin
        mx = red;
        if (green > mx)
        begin
            mx = green;
        end
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        delta = mx - mn;
        span  = (SPAN_BITS'(delta) << 2) + (SPAN_BITS'(delta) << 1);

        // Sector order decides ties: red first, then green, then blue.
        priority if (mx == red)
        begin
            h6 = SPAN_BITS'(green) - SPAN_BITS'(blue) + ((green < blue) ? span : '0);
        end
        else if (mx == green)
        begin
            h6 = (SPAN_BITS'(delta) << 1) + SPAN_BITS'(blue) - SPAN_BITS'(red);
        end
        else
        begin
            h6 = (SPAN_BITS'(delta) << 2) + SPAN_BITS'(red) - SPAN_BITS'(green);
        end

        sat_num = {delta, QUO_BITS'(0)} - SAT_NUM_BITS'(delta);

        data_next.grey    = (delta <= GREY_LIMIT);
        data_next.mx      = mx;
        data_next.sat_rem = sat_num[SAT_NUM_BITS-1:QUO_BITS];
        data_next.sat_low = sat_num[QUO_BITS-1:0];
        data_next.sat_quo = '0;
        data_next.hue_rem = h6;
        data_next.hue_quo = '0;
        data_next.span    = span;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== rtl/rgbhsv_cell.sv =====
module rgbhsv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  rgbhsv_pkg::stage_t data_in,
    output logic               valid_out,
    output rgbhsv_pkg::stage_t data_out
);
    import rgbhsv_pkg::*;

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;
    logic [CH_BITS:0]     sat_trial;
    logic [CH_BITS:0]     sat_diff;
    logic                 sat_ge;
    logic [SPAN_BITS:0]   hue_trial;
    logic [SPAN_BITS:0]   hue_diff;
    logic                 hue_ge;

    // Each cell resolves one quotient bit of both restoring divisions.
    always_comb
    begin
        sat_trial = {data_in.sat_rem, data_in.sat_low[QUO_BITS-1]};
        sat_diff  = sat_trial - {1'b0, data_in.mx};
        sat_ge    = (sat_trial >= {1'b0, data_in.mx});
        hue_trial = {data_in.hue_rem, 1'b0};
        hue_diff  = hue_trial - {1'b0, data_in.span};
        hue_ge    = (hue_trial >= {1'b0, data_in.span});

        data_next         = data_in;
        data_next.sat_rem = sat_ge ? sat_diff[CH_BITS-1:0] : sat_trial[CH_BITS-1:0];
        data_next.sat_low = {data_in.sat_low[QUO_BITS-2:0], 1'b0};
        data_next.sat_quo = {data_in.sat_quo[QUO_BITS-2:0], sat_ge};
        data_next.hue_rem = hue_ge ? hue_diff[SPAN_BITS-1:0] : hue_trial[SPAN_BITS-1:0];
        data_next.hue_quo = {data_in.hue_quo[QUO_BITS-2:0], hue_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== rtl/rgb_to_hsv.sv =====
// RGB to HSV pixel converter.
// Pixels enter on the pixel channel (red, green, blue, with pixel_valid and
// pixel_ready) and leave on the result channel (hue_turn, saturation_frac,
// brightness, with result_valid and result_ready). A transaction happens on
// a rising edge where valid and ready are both high.
// The prep register, which holds max, the grey flag, both dividends and the
// hue divisor six times delta, loads on the accepting edge, sixteen cells
// each resolve one quotient bit of the hue and saturation divisions, and the
// output register follows them. One pixel per cycle is taken while the
// receiver does not stall.
// A grey pixel repeats the hue of the last pixel that was not grey.
// Reset empties the pipeline, drops result_valid and clears the held hue
// to zero. When the receiver stalls, the whole pipeline freezes and
// pixel_ready falls in the same cycle, so no transaction is lost.
module rgb_to_hsv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [rgbhsv_pkg::CH_BITS-1:0]  red,
    input  logic [rgbhsv_pkg::CH_BITS-1:0]  green,
    input  logic [rgbhsv_pkg::CH_BITS-1:0]  blue,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [rgbhsv_pkg::QUO_BITS-1:0] hue_turn,
    output logic [rgbhsv_pkg::QUO_BITS-1:0] saturation_frac,
    output logic [rgbhsv_pkg::CH_BITS-1:0]  brightness
);
    import rgbhsv_pkg::*;

    logic                  advance;
    logic                  valid_chain [0:QUO_BITS];
    stage_t                data_chain  [0:QUO_BITS];
    stage_t                last;
    logic                  last_valid;
    logic                  result_valid_reg;
    logic [QUO_BITS-1:0]   hue_turn_reg;
    logic [QUO_BITS-1:0]   hue_turn_next;
    logic [QUO_BITS-1:0]   saturation_frac_reg;
    logic [QUO_BITS-1:0]   saturation_frac_next;
    logic [CH_BITS-1:0]    brightness_reg;
    logic [QUO_BITS-1:0]   held_hue_reg;

    assign advance     = !result_valid_reg || result_ready;
    assign pixel_ready = advance;

    rgbhsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .valid_in  (pixel_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .valid_out (valid_chain[0]),
        .data_out  (data_chain[0])
    );

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_cell
        rgbhsv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .valid_in  (valid_chain[i]),
            .data_in   (data_chain[i]),
            .valid_out (valid_chain[i+1]),
            .data_out  (data_chain[i+1])
        );
    end

    assign last       = data_chain[QUO_BITS];
    assign last_valid = valid_chain[QUO_BITS];

    always_comb
    begin
        hue_turn_next        = last.grey ? held_hue_reg : last.hue_quo;
        saturation_frac_next = (last.mx == '0) ? '0 : last.sat_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            held_hue_reg     <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= last_valid;
            if (last_valid && !last.grey)
            begin
                held_hue_reg <= last.hue_quo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_valid)
        begin
            hue_turn_reg        <= hue_turn_next;
            saturation_frac_reg <= saturation_frac_next;
            brightness_reg      <= last.mx;
        end
    end

    assign result_valid    = result_valid_reg;
    assign hue_turn        = hue_turn_reg;
    assign saturation_frac = saturation_frac_reg;
    assign brightness      = brightness_reg;

`ifndef ASSERT_OFF
    a_stall_holds_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> $stable(held_hue_reg))
        else $error("Held hue changed while the output was stalled.");

    a_black_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && brightness == '0) |-> (saturation_frac == '0))
        else $error("Black pixel produced nonzero saturation.");

    a_grey_keeps_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_valid && last.grey) |=> (hue_turn_reg == $past(held_hue_reg)))
        else $error("Grey pixel did not repeat the held hue.");

    a_new_hue_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_valid && !last.grey) |=> (held_hue_reg == hue_turn_reg))
        else $error("Held hue does not match the last computed hue.");
`endif

endmodule
